// ===== rtl/core/hhbp_pkg.sv =====
// Package for the HTTP header block parser.
// Holds the parse phase codes, byte role and error codes, character constants
// and the structs passed between the parser core and its step logic.
package hhbp_pkg;

	localparam int unsigned OffsetW = 12;
	localparam int unsigned PhaseW  = 4;
	localparam int unsigned RoleW   = 4;
	localparam int unsigned ErrW    = 3;

	localparam logic [OffsetW-1:0] LIMIT_RESET = 12'd255;
	localparam logic [OffsetW-1:0] OFFSET_MAX  = 12'hfff;

	// Parse phases.
	localparam logic [PhaseW-1:0] PH_START = 4'd0;
	localparam logic [PhaseW-1:0] PH_KEY   = 4'd1;
	localparam logic [PhaseW-1:0] PH_COLON = 4'd2;
	localparam logic [PhaseW-1:0] PH_SPACE = 4'd3;
	localparam logic [PhaseW-1:0] PH_VALUE = 4'd4;
	localparam logic [PhaseW-1:0] PH_CR    = 4'd5;
	localparam logic [PhaseW-1:0] PH_LF    = 4'd6;
	localparam logic [PhaseW-1:0] PH_ENDCR = 4'd7;
	localparam logic [PhaseW-1:0] PH_DONE  = 4'd8;

	// Byte roles.
	localparam logic [RoleW-1:0] ROLE_SKIP     = 4'd0;
	localparam logic [RoleW-1:0] ROLE_KEY      = 4'd1;
	localparam logic [RoleW-1:0] ROLE_COLON    = 4'd2;
	localparam logic [RoleW-1:0] ROLE_SPACE    = 4'd3;
	localparam logic [RoleW-1:0] ROLE_VALUE    = 4'd4;
	localparam logic [RoleW-1:0] ROLE_VALUE_CR = 4'd5;
	localparam logic [RoleW-1:0] ROLE_PAIR_LF  = 4'd6;
	localparam logic [RoleW-1:0] ROLE_BLANK_CR = 4'd7;
	localparam logic [RoleW-1:0] ROLE_DONE_LF  = 4'd8;
	localparam logic [RoleW-1:0] ROLE_BODY     = 4'd9;

	// Error codes.
	localparam logic [ErrW-1:0] ERR_NONE      = 3'd0;
	localparam logic [ErrW-1:0] ERR_KEY_BYTE  = 3'd1;
	localparam logic [ErrW-1:0] ERR_NO_SPACE  = 3'd2;
	localparam logic [ErrW-1:0] ERR_NO_LF     = 3'd3;
	localparam logic [ErrW-1:0] ERR_TOO_LONG  = 3'd4;
	localparam logic [ErrW-1:0] ERR_EMPTY     = 3'd5;

	// Characters.
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_COLON = 8'h3a;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		logic [PhaseW-1:0]  phase;
		logic [OffsetW-1:0] offset;
		logic [ErrW-1:0]    err;
	} hhbp_state_t;

	typedef struct packed {
		logic [RoleW-1:0] role;
		logic [ErrW-1:0]  err;
		logic             done;
	} hhbp_result_t;

endpackage

// ===== rtl/core/hhbp_step.sv =====
// Next-state and byte labeling logic of the HTTP header block parser.
// Purely combinational; depends on hhbp_pkg.
module hhbp_step
	import hhbp_pkg::*;
(
	input  hhbp_state_t        cur,
	input  logic [OffsetW-1:0] value_limit,
	input  logic [7:0]         data_byte,
	input  logic               restart,
	output hhbp_state_t        nxt,
	output hhbp_result_t       res
);

	hhbp_state_t        base;
	logic [OffsetW-1:0] off_inc;
	logic [RoleW-1:0]   role;
	logic               done;
	logic               is_crlf;

	always_comb begin
		base = restart ? hhbp_state_t'{phase: PH_START, offset: '0, err: ERR_NONE} : cur;
		nxt = base;
		role = ROLE_SKIP;
		done = 1'b0;
		is_crlf = (data_byte == CH_CR) || (data_byte == CH_LF);
		off_inc = (base.offset < OFFSET_MAX) ? base.offset + 12'd1 : base.offset;

		if (base.err == ERR_NONE) begin
			unique case (base.phase)
				PH_START, PH_LF: begin
					if (base.phase == PH_LF && data_byte == CH_CR) begin
						nxt.phase = PH_ENDCR;
						role = ROLE_BLANK_CR;
					end else if (base.phase == PH_START && is_crlf) begin
						role = ROLE_SKIP;
					end else if (data_byte == CH_COLON) begin
						nxt.err = ERR_EMPTY;
					end else if (is_crlf) begin
						nxt.err = ERR_KEY_BYTE;
					end else begin
						nxt.phase = PH_KEY;
						role = ROLE_KEY;
					end
				end
				PH_KEY: begin
					if (data_byte == CH_COLON) begin
						nxt.phase = PH_COLON;
						role = ROLE_COLON;
					end else if (is_crlf) begin
						nxt.err = ERR_KEY_BYTE;
					end else begin
						role = ROLE_KEY;
					end
				end
				PH_COLON: begin
					if (data_byte == CH_SPACE) begin
						nxt.phase = PH_SPACE;
						role = ROLE_SPACE;
					end else begin
						nxt.err = ERR_NO_SPACE;
					end
				end
				PH_SPACE: begin
					if (data_byte == CH_CR) begin
						nxt.err = ERR_EMPTY;
					end else begin
						nxt.offset = '0;
						nxt.phase = PH_VALUE;
						role = ROLE_VALUE;
					end
				end
				PH_VALUE: begin
					if (data_byte == CH_CR) begin
						nxt.phase = PH_CR;
						role = ROLE_VALUE_CR;
					end else begin
						// The counter saturates, so the largest limit never trips.
						nxt.offset = off_inc;
						if (off_inc > value_limit) begin
							nxt.err = ERR_TOO_LONG;
						end else begin
							role = ROLE_VALUE;
						end
					end
				end
				PH_CR, PH_ENDCR: begin
					if (data_byte != CH_LF) begin
						nxt.err = ERR_NO_LF;
					end else if (base.phase == PH_CR) begin
						nxt.phase = PH_LF;
						role = ROLE_PAIR_LF;
					end else begin
						nxt.phase = PH_DONE;
						role = ROLE_DONE_LF;
						done = 1'b1;
					end
				end
				default: begin
					// Done, and any phase code without meaning, counts as body.
					nxt.phase = PH_DONE;
					role = ROLE_BODY;
					done = 1'b1;
				end
			endcase
			if (nxt.err != ERR_NONE) begin
				role = ROLE_SKIP;
				done = 1'b0;
			end
		end

		res.role = role;
		res.err = nxt.err;
		res.done = done;
	end

endmodule

// ===== rtl/core/http_header_block_parser_core.sv =====
// Top level of the HTTP header block parser: input stage, parser state,
// result stage and the value limit register. Depends on hhbp_pkg, hhbp_step.
//
//  channel  handshake                  payload
//  in       in_valid / in_ready        data_byte[7:0], restart
//  out      out_valid / out_ready      byte_role[3:0], error_code[2:0], block_done
//  cfg      cfg_we (no wait)           cfg_wdata[11:0] -> value_limit
//
// One byte per cycle sustained while out_ready stays high. An accepted byte sits
// in the input register, then moves into the result register and is offered on
// the outputs from there. The parser state is updated as a byte moves from the
// input register into the result register.
// A stalled output holds the result stage; the input register takes one more
// byte and then in_ready falls. in_ready stays high while out_ready is.
// Reset clears the parser and sets value_limit to 255.
module http_header_block_parser_core
	import hhbp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [RoleW-1:0]   byte_role,
	output logic [ErrW-1:0]    error_code,
	output logic               block_done,
	input  logic               cfg_we,
	input  logic [OffsetW-1:0] cfg_wdata
);

	logic               valid_s1;
	logic [7:0]         data_s1;
	logic               restart_s1;
	logic               valid_s2;
	hhbp_result_t       res_s2;
	hhbp_state_t        state_q;
	hhbp_state_t        state_nxt;
	hhbp_result_t       res_nxt;
	logic [OffsetW-1:0] limit_q;
	logic               load_s2;
	logic               adv_s1;

	assign load_s2  = !valid_s2 || out_ready;
	assign adv_s1   = valid_s1 && load_s2;
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_we) begin
			limit_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			data_s1 <= data_byte;
			restart_s1 <= restart;
		end
	end

	hhbp_step u_step (
		.cur         (state_q),
		.value_limit (limit_q),
		.data_byte   (data_s1),
		.restart     (restart_s1),
		.nxt         (state_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_START, offset: '0, err: ERR_NONE};
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				state_q <= state_nxt;
			end
			if (load_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid  = valid_s2;
	assign byte_role  = res_s2.role;
	assign error_code = res_s2.err;
	assign block_done = res_s2.done;

	// An error stays latched until a byte arrives with restart set.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && !restart_s1 && state_q.err != ERR_NONE) |=>
			(state_q.err == $past(state_q.err)))
		else $error("parser error cleared without restart");

	// The end of the block is never reported together with an error.
	a_done_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done) |->
			(res_s2.err == ERR_NONE &&
			 (res_s2.role == ROLE_DONE_LF || res_s2.role == ROLE_BODY)))
		else $error("block_done with error or wrong role");

	// A consumer that keeps taking results never stalls the input.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while output is drained");

	// Result stage loads exactly when a byte leaves the input register.
	a_stage_move: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && load_s2) |=> valid_s2)
		else $error("byte lost between stages");

endmodule
